### rtl/pick_place_sort_sequencer_macros.svh
// Assertion macros shared by the checker files.
`ifndef PICK_PLACE_SORT_SEQUENCER_MACROS_SVH
`define PICK_PLACE_SORT_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked also during reset.
`define PPS_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### rtl/pps_pkg.sv
// Package with types, constants and target tables of the sort sequencer.
package pps_pkg;

    localparam int POSITION_WIDTH = 13;
    localparam int STEP_WIDTH     = 8;
    localparam int VEL_WIDTH      = 9;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 80;
    localparam int CFG_IDX_W      = 3;

    typedef logic [POSITION_WIDTH-1:0] t_pos;

    typedef enum logic [2:0] {
        CFG_X_STEP     = 3'd0,
        CFG_Y_STEP     = 3'd1,
        CFG_Z_STEP     = 3'd2,
        CFG_CAM_STEP   = 3'd3,
        CFG_GRIP_DWELL = 3'd4,
        CFG_SCAN_DWELL = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TOOL_NONE   = 2'd0,
        TOOL_ATTACH = 2'd1,
        TOOL_DETACH = 2'd2,
        TOOL_SCAN   = 2'd3
    } t_tool;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_SMALL  = 2'd1,
        CLS_LARGE  = 2'd2,
        CLS_REJECT = 2'd3
    } t_cls;

    typedef enum logic [5:0] {
        S_BOOT0      = 6'd0,
        S_FAULT      = 6'd1,
        S_BOOT2      = 6'd2,
        S_IDLE       = 6'd3,
        S_PAD_XY     = 6'd4,
        S_PAD_DOWN   = 6'd5,
        S_PAD_GRIP   = 6'd6,
        S_PAD_UP     = 6'd7,
        S_CELL_XY    = 6'd8,
        S_CELL_DOWN  = 6'd9,
        S_CELL_REL   = 6'd10,
        S_CAM_OUT    = 6'd11,
        S_SCAN       = 6'd12,
        S_CAM_BACK   = 6'd13,
        S_CELL_DOWN2 = 6'd14,
        S_CELL_GRIP  = 6'd15,
        S_CELL_UP    = 6'd16,
        S_SORT       = 6'd17,
        S_REJ_XY     = 6'd20,
        S_REJ_DOWN   = 6'd21,
        S_REJ_REL    = 6'd22,
        S_REJ_UP     = 6'd23,
        S_LRG_XY     = 6'd30,
        S_LRG_DOWN   = 6'd31,
        S_LRG_REL    = 6'd32,
        S_LRG_UP     = 6'd33,
        S_SML_XY     = 6'd40,
        S_SML_DOWN   = 6'd41,
        S_SML_REL    = 6'd42,
        S_SML_UP     = 6'd43,
        S_COUNT      = 6'd50,
        S_NEXT       = 6'd51,
        S_HOME       = 6'd60,
        S_DONE       = 6'd61
    } t_seq;

    localparam t_pos PAD_X0  = POSITION_WIDTH'(345);
    localparam t_pos PAD_Y0  = POSITION_WIDTH'(660);
    localparam t_pos PICK_Z  = POSITION_WIDTH'(1255);
    localparam t_pos CELL_X  = POSITION_WIDTH'(6425);
    localparam t_pos CELL_Y  = POSITION_WIDTH'(2960);
    localparam t_pos CELL_Z  = POSITION_WIDTH'(1072);
    localparam t_pos CAM_OUT = POSITION_WIDTH'(3500);
    localparam t_pos REJ_X   = POSITION_WIDTH'(3500);
    localparam t_pos REJ_Y   = POSITION_WIDTH'(1750);
    localparam t_pos REJ_Z   = POSITION_WIDTH'(1000);
    localparam t_pos LRG_X0  = POSITION_WIDTH'(2895);
    localparam t_pos SML_X0  = POSITION_WIDTH'(395);
    localparam t_pos BIN_Y0  = POSITION_WIDTH'(4060);

    function automatic t_cls class_of(input logic [3:0] obj);
        case (obj)
            4'd0, 4'd2, 4'd6, 4'd8: class_of = CLS_SMALL;
            4'd1, 4'd3, 4'd5, 4'd7: class_of = CLS_LARGE;
            default:                class_of = CLS_REJECT;
        endcase
    endfunction

    function automatic t_pos pad_dx(input logic [3:0] idx);
        case (idx)
            4'd0, 4'd1, 4'd2: pad_dx = POSITION_WIDTH'(0);
            4'd3, 4'd4, 4'd5: pad_dx = POSITION_WIDTH'(600);
            default:          pad_dx = POSITION_WIDTH'(1200);
        endcase
    endfunction

    function automatic t_pos pad_dy(input logic [3:0] idx);
        case (idx)
            4'd0, 4'd3, 4'd6: pad_dy = POSITION_WIDTH'(0);
            4'd1, 4'd4, 4'd7: pad_dy = POSITION_WIDTH'(800);
            default:          pad_dy = POSITION_WIDTH'(1600);
        endcase
    endfunction

    function automatic t_pos bin_dx(input logic [1:0] idx);
        bin_dx = idx[1] ? POSITION_WIDTH'(600) : POSITION_WIDTH'(0);
    endfunction

    function automatic t_pos bin_dy(input logic [1:0] idx);
        bin_dy = idx[0] ? POSITION_WIDTH'(800) : POSITION_WIDTH'(0);
    endfunction

endpackage

### rtl/pps_axis.sv
// One axis slew step: advance toward target, snap when within one step.
module pps_axis (
    input  pps_pkg::t_pos                       i_pos,
    input  pps_pkg::t_pos                       i_tgt,
    input  logic [pps_pkg::STEP_WIDTH-1:0]      i_step,
    output pps_pkg::t_pos                       o_pos,
    output logic signed [pps_pkg::VEL_WIDTH-1:0] o_vel
);
    logic [pps_pkg::STEP_WIDTH-1:0] step;
    pps_pkg::t_pos                  diff;
    pps_pkg::t_pos                  step_ext;
    logic                           up;

    always_comb begin
        step     = (i_step == '0) ? pps_pkg::STEP_WIDTH'(1) : i_step;
        step_ext = pps_pkg::POSITION_WIDTH'(step);
        up       = (i_tgt >= i_pos);
        diff     = up ? (i_tgt - i_pos) : (i_pos - i_tgt);
        if (diff <= step_ext) begin
            o_pos = i_tgt;
            o_vel = '0;
        end else if (up) begin
            o_pos = i_pos + step_ext;
            o_vel = $signed({1'b0, step});
        end else begin
            o_pos = i_pos - step_ext;
            o_vel = -$signed({1'b0, step});
        end
    end
endmodule

### rtl/pick_place_sort_sequencer.sv
// Top level of the pick-and-place sort sequencer.
//
// Usage:
//   Slave stream (i_s_axis_*): one transaction per 10 ms control tick.
//     tdata[0] start_button, [1] jam_sensor, [2] estop_ok, [3] guard_closed.
//   Master stream (o_m_axis_*): one result transaction per tick with the
//     drive flags, four axis positions, camera velocity, tool action,
//     object id/class and the sequence state after the tick.
//   Config channel (i_cfg_*): write step and dwell registers by index;
//     always ready, writes allowed while the stream is quiet.
// Output: the result is in the output register in the cycle after the tick
//   is accepted. Throughput: one tick per cycle while no result is held unaccepted; the whole tick update is
//   one pass of compare/add logic between the state and output registers.
// Reset: synchronous active low; sequence, axes, counters clear to zero
//   and registers load their defaults. The output register empties.
// Stall: while a result waits unaccepted, s_axis_tready drops only if the
//   receiver is not taking it this cycle; the held result stays stable.
module pick_place_sort_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // fields from bit 0: start_button, jam_sensor, estop_ok, guard_closed
    input  logic [pps_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // fields from bit 0: motor_on, alarm, jam_active, cam_position[13],
    // cam_velocity[9], x_position[13], y_position[13], z_position[13],
    // tool_action[2], object_id[4], object_type[2], sequence_state[6]
    output logic [pps_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pps_pkg::STEP_WIDTH-1:0]       i_cfg_data
);
    typedef logic [pps_pkg::STEP_WIDTH-1:0] t_byte;

    t_byte r_cfg [6];
    pps_pkg::t_seq r_state, n_state;
    pps_pkg::t_pos r_pos [4];
    pps_pkg::t_pos r_tgt [4], n_tgt [4];
    pps_pkg::t_pos n_pos [4];
    t_byte r_dwell, n_dwell;
    logic [3:0] r_obj, n_obj, r_done, n_done;
    pps_pkg::t_cls r_cls, n_cls;
    logic [2:0] r_lfill, n_lfill, r_sfill, n_sfill;
    logic signed [pps_pkg::VEL_WIDTH-1:0] vel [4];
    logic [pps_pkg::OUT_TDATA_W-1:0] r_tdata, n_tdata;
    logic r_tvalid;

    logic accept, start, jam, safe, running;
    pps_pkg::t_seq st;
    pps_pkg::t_tool tool;
    logic [8:0] dwell_inc;
    t_byte dwell_lim;
    logic dwell_hit;
    logic [3:0] idx9;
    logic [1:0] bidx;
    logic [3:0] done_inc;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_tvalid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tvalid = r_tvalid;

    assign start = i_s_axis_tdata[0];
    assign jam   = i_s_axis_tdata[1];
    assign safe  = i_s_axis_tdata[2] && i_s_axis_tdata[3];

    // Config writes; out-of-range indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[pps_pkg::CFG_X_STEP]     <= 8'd35;
            r_cfg[pps_pkg::CFG_Y_STEP]     <= 8'd25;
            r_cfg[pps_pkg::CFG_Z_STEP]     <= 8'd20;
            r_cfg[pps_pkg::CFG_CAM_STEP]   <= 8'd25;
            r_cfg[pps_pkg::CFG_GRIP_DWELL] <= 8'd100;
            r_cfg[pps_pkg::CFG_SCAN_DWELL] <= 8'd50;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pps_pkg::CFG_X_STEP:     r_cfg[pps_pkg::CFG_X_STEP]     <= i_cfg_data;
                pps_pkg::CFG_Y_STEP:     r_cfg[pps_pkg::CFG_Y_STEP]     <= i_cfg_data;
                pps_pkg::CFG_Z_STEP:     r_cfg[pps_pkg::CFG_Z_STEP]     <= i_cfg_data;
                pps_pkg::CFG_CAM_STEP:   r_cfg[pps_pkg::CFG_CAM_STEP]   <= i_cfg_data;
                pps_pkg::CFG_GRIP_DWELL: r_cfg[pps_pkg::CFG_GRIP_DWELL] <= i_cfg_data;
                pps_pkg::CFG_SCAN_DWELL: r_cfg[pps_pkg::CFG_SCAN_DWELL] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequence state and next-state logic for one tick.
    always_comb begin
        running   = (r_state >= pps_pkg::S_PAD_XY) && (r_state <= pps_pkg::S_DONE);
        st        = safe ? r_state : pps_pkg::S_FAULT;
        n_state   = st;
        n_tgt     = r_tgt;
        n_dwell   = r_dwell;
        n_obj     = r_obj;
        n_cls     = r_cls;
        n_done    = r_done;
        n_lfill   = r_lfill;
        n_sfill   = r_sfill;
        tool      = pps_pkg::TOOL_NONE;
        // shared dwell counter: the limit depends on the state
        dwell_lim = (st == pps_pkg::S_SCAN || st == pps_pkg::S_NEXT)
                    ? r_cfg[pps_pkg::CFG_SCAN_DWELL] : r_cfg[pps_pkg::CFG_GRIP_DWELL];
        dwell_inc = {1'b0, r_dwell} + 9'd1;
        dwell_hit = (dwell_inc >= {1'b0, dwell_lim});
        idx9      = (r_obj > 4'd8) ? 4'd8 : r_obj;
        bidx      = 2'd0;
        done_inc  = (r_done < 4'd15) ? r_done + 4'd1 : r_done;

        case (st)
            pps_pkg::S_BOOT0: if (safe) n_state = pps_pkg::S_FAULT;
            pps_pkg::S_FAULT: if (safe) n_state = pps_pkg::S_BOOT2;
            pps_pkg::S_BOOT2: if (safe) n_state = pps_pkg::S_IDLE;
            pps_pkg::S_IDLE, pps_pkg::S_DONE: if (start) n_state = pps_pkg::S_PAD_XY;
            pps_pkg::S_PAD_XY: begin
                n_tgt[0] = pps_pkg::PAD_X0 + pps_pkg::pad_dx(idx9);
                n_tgt[1] = pps_pkg::PAD_Y0 + pps_pkg::pad_dy(idx9);
                n_tgt[2] = '0;
                n_tgt[3] = '0;
                if (r_pos[0] == n_tgt[0] && r_pos[1] == n_tgt[1] &&
                    r_pos[2] == n_tgt[2] && r_pos[3] == n_tgt[3])
                    n_state = pps_pkg::S_PAD_DOWN;
            end
            pps_pkg::S_PAD_DOWN: begin
                n_tgt[2] = pps_pkg::PICK_Z;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_PAD_GRIP;
            end
            pps_pkg::S_PAD_GRIP: begin
                tool    = pps_pkg::TOOL_ATTACH;
                n_dwell = dwell_hit ? '0 : dwell_inc[7:0];
                if (dwell_hit) n_state = pps_pkg::S_PAD_UP;
            end
            pps_pkg::S_PAD_UP: begin
                n_tgt[2] = '0;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_CELL_XY;
            end
            pps_pkg::S_CELL_XY: begin
                n_tgt[0] = pps_pkg::CELL_X;
                n_tgt[1] = pps_pkg::CELL_Y;
                if (r_pos[0] == n_tgt[0] && r_pos[1] == n_tgt[1])
                    n_state = pps_pkg::S_CELL_DOWN;
            end
            pps_pkg::S_CELL_DOWN: begin
                n_tgt[2] = pps_pkg::CELL_Z;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_CELL_REL;
            end
            pps_pkg::S_CELL_REL: begin
                tool    = pps_pkg::TOOL_DETACH;
                n_dwell = dwell_hit ? '0 : dwell_inc[7:0];
                if (dwell_hit) n_state = pps_pkg::S_CAM_OUT;
            end
            pps_pkg::S_CAM_OUT: begin
                n_tgt[2] = '0;
                n_tgt[3] = pps_pkg::CAM_OUT;
                if (r_pos[2] == n_tgt[2] && r_pos[3] == n_tgt[3])
                    n_state = pps_pkg::S_SCAN;
            end
            pps_pkg::S_SCAN: begin
                tool    = pps_pkg::TOOL_SCAN;
                n_dwell = dwell_hit ? '0 : dwell_inc[7:0];
                if (dwell_hit) begin
                    n_cls   = (jam || r_obj > 4'd8) ? pps_pkg::CLS_REJECT
                                                    : pps_pkg::class_of(r_obj);
                    n_state = pps_pkg::S_CAM_BACK;
                end
            end
            pps_pkg::S_CAM_BACK: begin
                n_tgt[3] = '0;
                if (r_pos[3] == n_tgt[3]) n_state = pps_pkg::S_CELL_DOWN2;
            end
            pps_pkg::S_CELL_DOWN2: begin
                n_tgt[2] = pps_pkg::CELL_Z;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_CELL_GRIP;
            end
            pps_pkg::S_CELL_GRIP: begin
                tool    = pps_pkg::TOOL_ATTACH;
                n_dwell = dwell_hit ? '0 : dwell_inc[7:0];
                if (dwell_hit) n_state = pps_pkg::S_CELL_UP;
            end
            pps_pkg::S_CELL_UP: begin
                n_tgt[2] = '0;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_SORT;
            end
            pps_pkg::S_SORT: begin
                if (r_cls == pps_pkg::CLS_REJECT)     n_state = pps_pkg::S_REJ_XY;
                else if (r_cls == pps_pkg::CLS_LARGE) n_state = pps_pkg::S_LRG_XY;
                else                                  n_state = pps_pkg::S_SML_XY;
            end
            pps_pkg::S_REJ_XY: begin
                n_tgt[0] = pps_pkg::REJ_X;
                n_tgt[1] = pps_pkg::REJ_Y;
                if (r_pos[0] == n_tgt[0] && r_pos[1] == n_tgt[1])
                    n_state = pps_pkg::S_REJ_DOWN;
            end
            pps_pkg::S_REJ_DOWN: begin
                n_tgt[2] = pps_pkg::REJ_Z;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_REJ_REL;
            end
            pps_pkg::S_REJ_REL: begin
                tool    = pps_pkg::TOOL_DETACH;
                n_dwell = dwell_hit ? '0 : dwell_inc[7:0];
                if (dwell_hit) n_state = pps_pkg::S_REJ_UP;
            end
            pps_pkg::S_REJ_UP: begin
                n_tgt[2] = '0;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_COUNT;
            end
            pps_pkg::S_LRG_XY: begin
                bidx     = (r_lfill > 3'd3) ? 2'd3 : r_lfill[1:0];
                n_tgt[0] = pps_pkg::LRG_X0 + pps_pkg::bin_dx(bidx);
                n_tgt[1] = pps_pkg::BIN_Y0 + pps_pkg::bin_dy(bidx);
                if (r_pos[0] == n_tgt[0] && r_pos[1] == n_tgt[1])
                    n_state = pps_pkg::S_LRG_DOWN;
            end
            pps_pkg::S_LRG_DOWN: begin
                n_tgt[2] = pps_pkg::PICK_Z;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_LRG_REL;
            end
            pps_pkg::S_LRG_REL: begin
                tool    = pps_pkg::TOOL_DETACH;
                n_dwell = dwell_hit ? '0 : dwell_inc[7:0];
                if (dwell_hit) n_state = pps_pkg::S_LRG_UP;
            end
            pps_pkg::S_LRG_UP: begin
                n_tgt[2] = '0;
                if (r_pos[2] == n_tgt[2]) begin
                    if (r_lfill < 3'd4) n_lfill = r_lfill + 3'd1;
                    n_state = pps_pkg::S_COUNT;
                end
            end
            pps_pkg::S_SML_XY: begin
                bidx     = (r_sfill > 3'd3) ? 2'd3 : r_sfill[1:0];
                n_tgt[0] = pps_pkg::SML_X0 + pps_pkg::bin_dx(bidx);
                n_tgt[1] = pps_pkg::BIN_Y0 + pps_pkg::bin_dy(bidx);
                if (r_pos[0] == n_tgt[0] && r_pos[1] == n_tgt[1])
                    n_state = pps_pkg::S_SML_DOWN;
            end
            pps_pkg::S_SML_DOWN: begin
                n_tgt[2] = pps_pkg::PICK_Z;
                if (r_pos[2] == n_tgt[2]) n_state = pps_pkg::S_SML_REL;
            end
            pps_pkg::S_SML_REL: begin
                tool    = pps_pkg::TOOL_DETACH;
                n_dwell = dwell_hit ? '0 : dwell_inc[7:0];
                if (dwell_hit) n_state = pps_pkg::S_SML_UP;
            end
            pps_pkg::S_SML_UP: begin
                n_tgt[2] = '0;
                if (r_pos[2] == n_tgt[2]) begin
                    if (r_sfill < 3'd4) n_sfill = r_sfill + 3'd1;
                    n_state = pps_pkg::S_COUNT;
                end
            end
            pps_pkg::S_COUNT: begin
                n_done  = done_inc;
                n_state = (done_inc < 4'd9) ? pps_pkg::S_NEXT : pps_pkg::S_HOME;
            end
            pps_pkg::S_NEXT: begin
                n_obj   = (r_done > 4'd8) ? 4'd8 : r_done;
                n_dwell = dwell_hit ? '0 : dwell_inc[7:0];
                if (dwell_hit) n_state = pps_pkg::S_PAD_XY;
            end
            pps_pkg::S_HOME: begin
                n_done   = '0;
                n_lfill  = '0;
                n_sfill  = '0;
                n_obj    = '0;
                n_tgt[0] = pps_pkg::PAD_X0;
                n_tgt[1] = pps_pkg::PAD_Y0;
                if (r_pos[0] == n_tgt[0] && r_pos[1] == n_tgt[1])
                    n_state = pps_pkg::S_DONE;
            end
            default: n_state = pps_pkg::S_IDLE;
        endcase
    end

    // Slew all four axes toward this tick's targets.
    for (genvar a = 0; a < 4; a++) begin : g_axis
        pps_axis u_axis (
            .i_pos  (r_pos[a]),
            .i_tgt  (n_tgt[a]),
            .i_step (r_cfg[a]),
            .o_pos  (n_pos[a]),
            .o_vel  (vel[a])
        );
    end

    // Pack the result transaction.
    always_comb begin
        n_tdata = {2'b00, n_state, n_cls, n_obj, tool, n_pos[2], n_pos[1], n_pos[0],
                   vel[3], n_pos[3], jam && running, !safe, safe && running};
    end

    // Advance the tick state on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pps_pkg::S_BOOT0;
            r_dwell <= '0;
            r_obj   <= '0;
            r_cls   <= pps_pkg::CLS_NONE;
            r_done  <= '0;
            r_lfill <= '0;
            r_sfill <= '0;
            for (int a = 0; a < 4; a++) begin
                r_pos[a] <= '0;
                r_tgt[a] <= '0;
            end
        end else if (accept) begin
            r_state <= n_state;
            r_dwell <= n_dwell;
            r_obj   <= n_obj;
            r_cls   <= n_cls;
            r_done  <= n_done;
            r_lfill <= n_lfill;
            r_sfill <= n_sfill;
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
        end
    end

    // Output register: load on accept, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (accept) begin
            r_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tdata <= n_tdata;
        end
    end
endmodule

### rtl/pps_checker.sv
// Port-level checker for the sort sequencer, bound to the top level.
`include "pick_place_sort_sequencer_macros.svh"

module pps_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic [pps_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready
);
    logic [5:0] out_state;
    logic       out_alarm;
    logic       out_motor;
    logic       held;

    assign out_state = o_m_axis_tdata[77:72];
    assign out_alarm = o_m_axis_tvalid && o_m_axis_tdata[1];
    assign out_motor = o_m_axis_tvalid && o_m_axis_tdata[0];
    assign held      = o_m_axis_tvalid && !i_m_axis_tready;

    // a fault result always reports the fault state
    `PPS_ASSERT_IMP(a_alarm_state, i_clk, i_rst_n, out_alarm, out_state == pps_pkg::S_FAULT)
    // motors never run while the safety chain is open
    `PPS_ASSERT_IMP(a_motor_safe, i_clk, i_rst_n, out_motor, !o_m_axis_tdata[1])
    // input stalls only behind a held, untaken result
    `PPS_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_s_axis_tready, held)
    // a stalled result holds its payload
    `PPS_ASSERT_NXT(a_hold, i_clk, i_rst_n, held, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // reset empties the output register
    `PPS_ASSERT_ALW(a_reset, i_clk, $past(!i_rst_n), !o_m_axis_tvalid)
endmodule

bind pick_place_sort_sequencer pps_checker u_pps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

### verif/tb_pick_place_sort_sequencer.sv
// Self-checking testbench for the pick-and-place sort sequencer top level.
`timescale 1ns / 1ps

module tb_pick_place_sort_sequencer;

    // Unpacked view of one result transaction.
    typedef struct {
        logic          motor_on;
        logic          alarm;
        logic          jam_active;
        pps_pkg::t_pos cam_pos;
        logic [8:0]    cam_vel;
        pps_pkg::t_pos x_pos;
        pps_pkg::t_pos y_pos;
        pps_pkg::t_pos z_pos;
        logic [1:0]    tool;
        logic [3:0]    obj_id;
        logic [1:0]    obj_class;
        logic [5:0]    seq;
    } t_tick_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic [pps_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [pps_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [pps_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [pps_pkg::STEP_WIDTH-1:0]  i_cfg_data;

    pick_place_sort_sequencer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Ticks waiting to be sent and results the predictor expects.
    logic [3:0]   tick_queue[$];
    t_tick_result expected_results[$];
    int           tx_idle_pct;
    int           rx_idle_pct;
    bit           tick_taken;
    int           n_errors;
    int           n_ticks;
    int           n_sorted;

    // Predictor copy of the sequencer state and its registers.
    logic [7:0]    cfg_reg[6];
    logic [5:0]    seq_q;
    pps_pkg::t_pos axis_pos[4];
    pps_pkg::t_pos axis_tgt[4];
    logic [7:0]    dwell_q;
    logic [3:0]    obj_q;
    pps_pkg::t_cls cls_q;
    logic [3:0]    done_q;
    logic [2:0]    large_q;
    logic [2:0]    small_q;

    // Pad object classes in pick order.
    const pps_pkg::t_cls pad_class[9] = '{
        pps_pkg::CLS_SMALL, pps_pkg::CLS_LARGE, pps_pkg::CLS_SMALL,
        pps_pkg::CLS_LARGE, pps_pkg::CLS_REJECT, pps_pkg::CLS_LARGE,
        pps_pkg::CLS_SMALL, pps_pkg::CLS_LARGE, pps_pkg::CLS_SMALL};

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic bit dwell_expired(input logic [7:0] lim);
        int n;
        n = int'(dwell_q) + 1;
        if (n >= int'(lim)) begin
            dwell_q = '0;
            return 1'b1;
        end
        dwell_q = n[7:0];
        return 1'b0;
    endfunction

    // Slew one axis toward its target; return the signed step as 9 bits.
    function automatic logic [8:0] slew_axis(input int a, input logic [7:0] step_raw);
        int p, t, s;
        p = int'(axis_pos[a]);
        t = int'(axis_tgt[a]);
        s = (step_raw == 0) ? 1 : int'(step_raw);
        if (t >= p) begin
            if (t - p <= s) begin
                axis_pos[a] = pps_pkg::POSITION_WIDTH'(t);
                return '0;
            end
            axis_pos[a] = pps_pkg::POSITION_WIDTH'(p + s);
            return 9'(s);
        end
        if (p - t <= s) begin
            axis_pos[a] = pps_pkg::POSITION_WIDTH'(t);
            return '0;
        end
        axis_pos[a] = pps_pkg::POSITION_WIDTH'(p - s);
        return 9'(512 - s);
    endfunction

    function automatic bit on_target(input int a);
        return axis_pos[a] == axis_tgt[a];
    endfunction

    // Move Z to a height, advance when it is there.
    function automatic void z_then(input int z, input pps_pkg::t_seq nxt);
        axis_tgt[2] = pps_pkg::POSITION_WIDTH'(z);
        if (on_target(2)) seq_q = nxt;
    endfunction

    function automatic void aim_xy(input int x, input int y);
        axis_tgt[0] = pps_pkg::POSITION_WIDTH'(x);
        axis_tgt[1] = pps_pkg::POSITION_WIDTH'(y);
    endfunction

    // Advance the sequencer by one control tick.
    function automatic t_tick_result advance_sequencer(input logic [3:0] tick);
        t_tick_result r;
        bit start, jam, safe, running;
        logic [1:0] tool;
        int idx;
        start   = tick[0];
        jam     = tick[1];
        safe    = tick[2] && tick[3];
        running = seq_q >= pps_pkg::S_PAD_XY && seq_q <= pps_pkg::S_DONE;
        tool    = pps_pkg::TOOL_NONE;

        if (!safe) seq_q = pps_pkg::S_FAULT;
        case (seq_q)
            pps_pkg::S_BOOT0, pps_pkg::S_FAULT, pps_pkg::S_BOOT2: begin
                if (safe) seq_q = seq_q + 6'd1;
            end
            pps_pkg::S_IDLE, pps_pkg::S_DONE: begin
                if (start) seq_q = pps_pkg::S_PAD_XY;
            end
            pps_pkg::S_PAD_XY: begin
                idx = (obj_q > 8) ? 8 : int'(obj_q);
                aim_xy(345 + 600 * (idx / 3), 660 + 800 * (idx % 3));
                axis_tgt[2] = '0;
                axis_tgt[3] = '0;
                if (on_target(0) && on_target(1) && on_target(2) && on_target(3))
                    seq_q = pps_pkg::S_PAD_DOWN;
            end
            pps_pkg::S_PAD_DOWN: z_then(1255, pps_pkg::S_PAD_GRIP);
            pps_pkg::S_PAD_GRIP: begin
                tool = pps_pkg::TOOL_ATTACH;
                if (dwell_expired(cfg_reg[pps_pkg::CFG_GRIP_DWELL])) seq_q = pps_pkg::S_PAD_UP;
            end
            pps_pkg::S_PAD_UP: z_then(0, pps_pkg::S_CELL_XY);
            pps_pkg::S_CELL_XY: begin
                aim_xy(6425, 2960);
                if (on_target(0) && on_target(1)) seq_q = pps_pkg::S_CELL_DOWN;
            end
            pps_pkg::S_CELL_DOWN: z_then(1072, pps_pkg::S_CELL_REL);
            pps_pkg::S_CELL_REL: begin
                tool = pps_pkg::TOOL_DETACH;
                if (dwell_expired(cfg_reg[pps_pkg::CFG_GRIP_DWELL])) seq_q = pps_pkg::S_CAM_OUT;
            end
            pps_pkg::S_CAM_OUT: begin
                axis_tgt[2] = '0;
                axis_tgt[3] = pps_pkg::POSITION_WIDTH'(3500);
                if (on_target(2) && on_target(3)) seq_q = pps_pkg::S_SCAN;
            end
            pps_pkg::S_SCAN: begin
                tool = pps_pkg::TOOL_SCAN;
                if (dwell_expired(cfg_reg[pps_pkg::CFG_SCAN_DWELL])) begin
                    cls_q = (jam || obj_q > 8) ? pps_pkg::CLS_REJECT : pad_class[obj_q];
                    seq_q = pps_pkg::S_CAM_BACK;
                end
            end
            pps_pkg::S_CAM_BACK: begin
                axis_tgt[3] = '0;
                if (on_target(3)) seq_q = pps_pkg::S_CELL_DOWN2;
            end
            pps_pkg::S_CELL_DOWN2: z_then(1072, pps_pkg::S_CELL_GRIP);
            pps_pkg::S_CELL_GRIP: begin
                tool = pps_pkg::TOOL_ATTACH;
                if (dwell_expired(cfg_reg[pps_pkg::CFG_GRIP_DWELL])) seq_q = pps_pkg::S_CELL_UP;
            end
            pps_pkg::S_CELL_UP: z_then(0, pps_pkg::S_SORT);
            pps_pkg::S_SORT: begin
                if (cls_q == pps_pkg::CLS_REJECT) seq_q = pps_pkg::S_REJ_XY;
                else if (cls_q == pps_pkg::CLS_LARGE) seq_q = pps_pkg::S_LRG_XY;
                else seq_q = pps_pkg::S_SML_XY;
            end
            pps_pkg::S_REJ_XY: begin
                aim_xy(3500, 1750);
                if (on_target(0) && on_target(1)) seq_q = pps_pkg::S_REJ_DOWN;
            end
            pps_pkg::S_REJ_DOWN: z_then(1000, pps_pkg::S_REJ_REL);
            pps_pkg::S_REJ_REL: begin
                tool = pps_pkg::TOOL_DETACH;
                if (dwell_expired(cfg_reg[pps_pkg::CFG_GRIP_DWELL])) seq_q = pps_pkg::S_REJ_UP;
            end
            pps_pkg::S_REJ_UP: z_then(0, pps_pkg::S_COUNT);
            pps_pkg::S_LRG_XY, pps_pkg::S_SML_XY: begin
                // Bin slot: X steps 600 on slot bit 1, Y steps 800 on slot bit 0.
                if (seq_q == pps_pkg::S_LRG_XY) idx = (large_q > 3) ? 3 : int'(large_q);
                else idx = (small_q > 3) ? 3 : int'(small_q);
                aim_xy(((seq_q == pps_pkg::S_LRG_XY) ? 2895 : 395) + 600 * (idx / 2),
                       4060 + 800 * (idx % 2));
                if (on_target(0) && on_target(1)) seq_q = seq_q + 6'd1;
            end
            pps_pkg::S_LRG_DOWN, pps_pkg::S_SML_DOWN:
                z_then(1255, pps_pkg::t_seq'(seq_q + 6'd1));
            pps_pkg::S_LRG_REL, pps_pkg::S_SML_REL: begin
                tool = pps_pkg::TOOL_DETACH;
                if (dwell_expired(cfg_reg[pps_pkg::CFG_GRIP_DWELL])) seq_q = seq_q + 6'd1;
            end
            pps_pkg::S_LRG_UP, pps_pkg::S_SML_UP: begin
                axis_tgt[2] = '0;
                if (on_target(2)) begin
                    if (seq_q == pps_pkg::S_LRG_UP && large_q < 4) large_q++;
                    if (seq_q == pps_pkg::S_SML_UP && small_q < 4) small_q++;
                    seq_q = pps_pkg::S_COUNT;
                end
            end
            pps_pkg::S_COUNT: begin
                n_sorted++;
                if (done_q < 15) done_q++;
                seq_q = (done_q < 9) ? pps_pkg::S_NEXT : pps_pkg::S_HOME;
            end
            pps_pkg::S_NEXT: begin
                obj_q = (done_q > 8) ? 4'd8 : done_q;
                if (dwell_expired(cfg_reg[pps_pkg::CFG_SCAN_DWELL])) seq_q = pps_pkg::S_PAD_XY;
            end
            pps_pkg::S_HOME: begin
                done_q  = '0;
                large_q = '0;
                small_q = '0;
                obj_q   = '0;
                aim_xy(345, 660);
                if (on_target(0) && on_target(1)) seq_q = pps_pkg::S_DONE;
            end
            default: seq_q = pps_pkg::S_IDLE;
        endcase

        void'(slew_axis(0, cfg_reg[pps_pkg::CFG_X_STEP]));
        void'(slew_axis(1, cfg_reg[pps_pkg::CFG_Y_STEP]));
        void'(slew_axis(2, cfg_reg[pps_pkg::CFG_Z_STEP]));
        r.cam_vel    = slew_axis(3, cfg_reg[pps_pkg::CFG_CAM_STEP]);
        r.motor_on   = safe && running;
        r.alarm      = !safe;
        r.jam_active = jam && running;
        r.cam_pos    = axis_pos[3];
        r.x_pos      = axis_pos[0];
        r.y_pos      = axis_pos[1];
        r.z_pos      = axis_pos[2];
        r.tool       = tool;
        r.obj_id     = obj_q;
        r.obj_class  = cls_q;
        r.seq        = seq_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // Predict each accepted tick and check each accepted result.
    always @(posedge i_clk) begin
        t_tick_result e;
        logic [pps_pkg::OUT_TDATA_W-1:0] d;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            expected_results.push_back(advance_sequencer(i_s_axis_tdata[3:0]));
            tick_taken = 1'b1;
            n_ticks++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            d = o_m_axis_tdata;
            if (expected_results.size() == 0) begin
                $error("result transaction with no tick pending");
                n_errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("motor_on", e.motor_on, d[0]);
                check_field("alarm", e.alarm, d[1]);
                check_field("jam_active", e.jam_active, d[2]);
                check_field("cam_position", e.cam_pos, d[15:3]);
                check_field("cam_velocity", e.cam_vel, d[24:16]);
                check_field("x_position", e.x_pos, d[37:25]);
                check_field("y_position", e.y_pos, d[50:38]);
                check_field("z_position", e.z_pos, d[63:51]);
                check_field("tool_action", e.tool, d[65:64]);
                check_field("object_id", e.obj_id, d[69:66]);
                check_field("object_type", e.obj_class, d[71:70]);
                check_field("sequence_state", e.seq, d[77:72]);
            end
        end
    end

    // Tick driver and result-side backpressure.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            if (!i_s_axis_tvalid || tick_taken) begin
                tick_taken = 1'b0;
                if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_s_axis_tdata  <= {4'b0, tick_queue.pop_front()};
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic write_reg(input pps_pkg::t_cfg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] xs, ys, zs, cs, gd, sd);
        write_reg(pps_pkg::CFG_X_STEP, xs);
        write_reg(pps_pkg::CFG_Y_STEP, ys);
        write_reg(pps_pkg::CFG_Z_STEP, zs);
        write_reg(pps_pkg::CFG_CAM_STEP, cs);
        write_reg(pps_pkg::CFG_GRIP_DWELL, gd);
        write_reg(pps_pkg::CFG_SCAN_DWELL, sd);
    endtask

    // Hold until every queued tick is sent and every result is back.
    task automatic drain;
        while (tick_queue.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Queue random ticks: mostly safe, with rare faults of either kind.
    task automatic queue_random(input int n);
        logic [3:0] t;
        repeat (n) begin
            t[0] = ($urandom_range(9) < 3);
            t[1] = ($urandom_range(4) == 0);
            if ($urandom_range(99) >= 4) begin
                t[3:2] = 2'b11;
            end else begin
                t[3:2] = 2'($urandom_range(2));
            end
            tick_queue.push_back(t);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tvalid = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        tick_taken      = 1'b0;
        n_errors        = 0;
        n_ticks         = 0;
        n_sorted        = 0;
        tx_idle_pct     = 9;
        rx_idle_pct     = 49;
        cfg_reg = '{8'd35, 8'd25, 8'd20, 8'd25, 8'd100, 8'd50};
        seq_q   = pps_pkg::S_BOOT0;
        dwell_q = '0;
        obj_q   = '0;
        cls_q   = pps_pkg::CLS_NONE;
        done_q  = '0;
        large_q = '0;
        small_q = '0;
        for (int a = 0; a < 4; a++) begin
            axis_pos[a] = '0;
            axis_tgt[a] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: boot with faults of each kind, then every input pattern.
        tick_queue.push_back(4'b0000);
        tick_queue.push_back(4'b0100);
        tick_queue.push_back(4'b1000);
        tick_queue.push_back(4'b1100);
        tick_queue.push_back(4'b1100);
        tick_queue.push_back(4'b1100);
        for (int v = 0; v < 16; v++) tick_queue.push_back(4'(v));
        tick_queue.push_back(4'b1101);
        tick_queue.push_back(4'b1111);
        drain();

        // Slowest corner: zero steps act as one, zero and full dwells.
        write_all(8'd0, 8'd1, 8'd0, 8'd1, 8'd255, 8'd0);
        queue_random(30);
        drain();

        // Fastest slew, shortest dwells.
        write_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd1);
        queue_random(270);
        drain();

        tx_idle_pct = 49;
        rx_idle_pct = 9;
        write_all(8'd200, 8'd180, 8'd255, 8'd128, 8'd3, 8'd2);
        queue_random(270);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_all(8'($urandom_range(255, 150)), 8'($urandom_range(255, 150)),
                  8'($urandom_range(255, 150)), 8'($urandom_range(255, 150)),
                  8'($urandom_range(4, 1)), 8'($urandom_range(4, 1)));
        queue_random(270);
        drain();

        $display("Sent %0d ticks over five register settings; %0d objects finished sorting.",
                 n_ticks, n_sorted);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout waiting for the sequencer");
        $display("Test completed with failures");
        $finish;
    end

endmodule
